### design/tfc_pkg.sv
package tfc_pkg;

    // Field widths fixed by the interface.
    localparam int SAMPLE_W    = 16;
    localparam int COLOR_W     = 8;
    localparam int STAT_W      = 17;
    localparam int POS_W       = 10;
    localparam int DIM_CFG_W   = 11;
    localparam int TEMP_W      = 16;
    localparam int RANGE_W     = 15;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;

    // Internal arithmetic widths.
    localparam int SUM_W       = 40;
    localparam int DIFF_W      = 18;
    localparam int SC_FRAC_BITS = 10;
    localparam int SC_W        = SC_FRAC_BITS + 1;
    localparam int PROD_TEN_W  = 32;

    // Raw sample offset: the sensor adds 1000 tenths of a degree.
    localparam logic signed [STAT_W-1:0] RAW_OFFSET = 17'sd1000;

    // Truncating divide by ten as a reciprocal multiply, exact below 2^18.
    localparam logic [SAMPLE_W-1:0] RECIP_TEN   = 16'd52429;
    localparam int                  RECIP_SHIFT = 19;

    // Palette breakpoints on the mirrored scale m = 1024 - scaled.
    localparam logic [SC_W-1:0] SC_FULL     = 11'd1024;
    localparam logic [SC_W-1:0] PAL_KNEE_1  = 11'd256;
    localparam logic [SC_W-1:0] PAL_KNEE_2  = 11'd512;
    localparam logic [SC_W-1:0] PAL_KNEE_3  = 11'd640;
    localparam logic [SC_W-1:0] PAL_KNEE_4  = 11'd896;
    localparam logic [SC_W-1:0] PAL_SAT     = 11'd255;
    localparam logic [COLOR_W-1:0] COLOR_MAX = 8'd255;
    localparam logic [COLOR_W-1:0] BLUE_MID  = 8'd128;

    // Register reset values.
    localparam logic [DIM_CFG_W-1:0] WIDTH_RESET  = 11'd160;
    localparam logic [DIM_CFG_W-1:0] HEIGHT_RESET = 11'd120;
    localparam logic [TEMP_W-1:0]    TMIN_RESET   = 16'd0;
    localparam logic [RANGE_W-1:0]   RANGE_RESET  = 15'd100;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_TEMP_MIN     = 2'd2,
        REG_TEMP_RANGE   = 2'd3
    } cfg_reg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic mul_load;
        logic diff_load;
        logic sc_sat;
        logic pdiv_start;
        logic sc_from_div;
        logic adiv_start;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sc_direct;
        logic fend;
        logic div_idle;
        logic out_free;
    } status_t;

endpackage

### design/tfc_divider.sv
module tfc_divider #(
    parameter int DVD_W  = 40,
    parameter int DVS_W  = 22,
    parameter int STEP_W = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DVS_W-1:0]  rem_init,
    input  logic [DVD_W-1:0]  dvd_init,
    input  logic [DVS_W-1:0]  divisor,
    input  logic [STEP_W-1:0] steps,
    output logic              busy,
    output logic [DVD_W-1:0]  quotient
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  rem_next;
    logic [DVD_W-1:0]  quo_reg;
    logic [DVD_W-1:0]  quo_next;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W:0]    trial;
    logic [DVS_W+1:0]  trial_diff;
    logic              fits;

    assign busy     = (step_reg != '0);
    assign quotient = quo_reg;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb
    begin
        trial      = {rem_reg, quo_reg[DVD_W-1]};
        trial_diff = {1'b0, trial} - {2'b00, dvs_reg};
        fits       = ~trial_diff[DVS_W+1];
        rem_next   = fits ? trial_diff[DVS_W-1:0] : trial[DVS_W-1:0];
        quo_next   = {quo_reg[DVD_W-2:0], fits};
        step_next  = step_reg - STEP_W'(1);
    end

    // Step counter is control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (start)
        begin
            step_reg <= steps;
        end
        else if (busy)
        begin
            step_reg <= step_next;
        end
    end

    // Remainder, quotient and divisor registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            quo_reg <= dvd_init;
            dvs_reg <= divisor;
        end
        else if (busy)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

endmodule

### design/tfc_ctrl.sv
module tfc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  tfc_pkg::status_t status,
    output tfc_pkg::cmd_t    cmd
);
    import tfc_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_MUL    = 8'b0000_0010,
        ST_DIFF   = 8'b0000_0100,
        ST_SCALE  = 8'b0000_1000,
        ST_PDIV   = 8'b0001_0000,
        ST_ASTART = 8'b0010_0000,
        ST_ADIV   = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Only one pixel is in flight; new transactions wait for idle.
    assign in_stall = (state_reg != ST_IDLE);

    // Sequencing of one pixel through the datapath.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.diff_load = 1'b1;
                state_next    = ST_SCALE;
            end
            ST_SCALE:
            begin
                if (status.sc_direct)
                begin
                    cmd.sc_sat = 1'b1;
                    state_next = status.fend ? ST_ASTART : ST_OUT;
                end
                else
                begin
                    cmd.pdiv_start = 1'b1;
                    state_next     = ST_PDIV;
                end
            end
            ST_PDIV:
            begin
                if (status.div_idle)
                begin
                    cmd.sc_from_div = 1'b1;
                    state_next      = status.fend ? ST_ASTART : ST_OUT;
                end
            end
            ST_ASTART:
            begin
                cmd.adiv_start = 1'b1;
                state_next     = ST_ADIV;
            end
            ST_ADIV:
            begin
                if (status.div_idle)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### design/tfc_datapath.sv
module tfc_datapath #(
    parameter int MAX_DIM     = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [tfc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tfc_pkg::CFG_W-1:0]            cfg_data,
    input  logic signed [tfc_pkg::SAMPLE_W-1:0]  sample,
    input  logic                                 out_stall,
    input  tfc_pkg::cmd_t                        cmd,
    output tfc_pkg::status_t                     status,
    output logic                                 out_valid,
    output logic [tfc_pkg::COLOR_W-1:0]          blue,
    output logic [tfc_pkg::COLOR_W-1:0]          green,
    output logic [tfc_pkg::COLOR_W-1:0]          red,
    output logic                                 frame_end,
    output logic signed [tfc_pkg::STAT_W-1:0]    max_tenths,
    output logic [tfc_pkg::POS_W-1:0]            max_column,
    output logic [tfc_pkg::POS_W-1:0]            max_row,
    output logic signed [tfc_pkg::STAT_W-1:0]    average_tenths
);
    import tfc_pkg::*;

    localparam int CNT_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CMP_W  = (DIM_W > DIM_CFG_W) ? DIM_W : DIM_CFG_W;
    localparam int PROD_W = 2 * DIM_W;
    localparam int DVS_W  = (PROD_W > RANGE_W) ? PROD_W : RANGE_W;
    localparam int STEP_W = $clog2(SUM_W + 1);
    localparam int SHIFT  = SAMPLE_W - SAMPLE_BITS;

    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } pixel_t;

    // Five-segment false-color palette on the mirrored scale.
    function automatic pixel_t palette(input logic [SC_W-1:0] sc);
        logic [SC_W-1:0] m;
        logic [SC_W-1:0] t;
        pixel_t          px;
        begin
            m  = SC_FULL - sc;
            px = '0;
            if (m < PAL_KNEE_1)
            begin
                t        = PAL_SAT - m;
                px.blue  = t[COLOR_W-1:0];
                px.green = COLOR_MAX;
                px.red   = COLOR_MAX;
            end
            else if (m < PAL_KNEE_2)
            begin
                t        = PAL_KNEE_2 - m;
                px.green = t[COLOR_W-1:0];
                px.red   = COLOR_MAX;
            end
            else if (m < PAL_KNEE_3)
            begin
                t       = m - PAL_KNEE_2;
                px.blue = t[COLOR_W-1:0];
                px.red  = COLOR_MAX;
            end
            else if (m < PAL_KNEE_4)
            begin
                t       = PAL_KNEE_4 - m;
                px.blue = BLUE_MID;
                px.red  = (t > PAL_SAT) ? COLOR_MAX : t[COLOR_W-1:0];
            end
            else
            begin
                t       = SC_FULL - m;
                px.blue = t[COLOR_W-1:0];
            end
            return px;
        end
    endfunction

    // Configuration registers.
    logic [DIM_CFG_W-1:0]     frame_width_reg;
    logic [DIM_CFG_W-1:0]     frame_height_reg;
    logic signed [TEMP_W-1:0] temp_min_reg;
    logic [RANGE_W-1:0]       temp_range_reg;

    // Raster position and frame statistics.
    logic [CNT_W-1:0]           col_reg;
    logic [CNT_W-1:0]           row_reg;
    logic signed [SAMPLE_W-1:0] max_reg;
    logic [CNT_W-1:0]           max_col_reg;
    logic [CNT_W-1:0]           max_row_reg;
    logic signed [SUM_W-1:0]    sum_reg;

    // Per-pixel working registers.
    logic signed [SAMPLE_W-1:0] samp_reg;
    logic                       fend_reg;
    logic [PROD_TEN_W-1:0]      prod_reg;
    logic                       off_neg_reg;
    logic signed [DIFF_W-1:0]   diff_reg;
    logic [SC_W-1:0]            sc_reg;

    // Output register.
    logic                       out_valid_reg;
    pixel_t                     pix_reg;
    logic                       frame_end_reg;
    logic signed [STAT_W-1:0]   max_tenths_reg;
    logic [POS_W-1:0]           max_column_reg;
    logic [POS_W-1:0]           max_row_out_reg;
    logic signed [STAT_W-1:0]   average_reg;

    logic [CMP_W-1:0]           fw_ext;
    logic [CMP_W-1:0]           fh_ext;
    logic [DIM_W-1:0]           width_eff;
    logic [DIM_W-1:0]           height_eff;
    logic                       last_col;
    logic                       last_row;
    logic                       frame_start;
    logic signed [SAMPLE_W-1:0] smp_shl;
    logic signed [SAMPLE_W-1:0] smp;
    logic signed [STAT_W-1:0]   off_in;
    logic signed [SUM_W-1:0]    off_sum;
    logic signed [STAT_W-1:0]   off_s;
    logic [STAT_W-1:0]          off_mag;
    logic [DIFF_W-1:0]          deg_mag;
    logic signed [DIFF_W-1:0]   deg_v;
    logic signed [DIFF_W-1:0]   tmin_ext;
    logic [RANGE_W-1:0]         range_eff;
    logic                       sc_zero;
    logic                       sc_full;
    logic                       sum_neg;
    logic [SUM_W-1:0]           sum_mag;
    logic [PROD_W-1:0]          dim_prod;
    logic                       div_start;
    logic [DVS_W-1:0]           div_rem;
    logic [SUM_W-1:0]           div_dvd;
    logic [DVS_W-1:0]           div_dvs;
    logic [STEP_W-1:0]          div_steps;
    logic                       div_busy;
    logic [SUM_W-1:0]           div_quo;
    logic [STAT_W-1:0]          avg_mag;
    logic                       out_free;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
            temp_min_reg     <= TMIN_RESET;
            temp_range_reg   <= RANGE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[DIM_CFG_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[DIM_CFG_W-1:0];
                REG_TEMP_MIN:     temp_min_reg     <= cfg_data;
                REG_TEMP_RANGE:   temp_range_reg   <= cfg_data[RANGE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Frame dimensions: zero counts as one, oversize counts as the maximum.
    always_comb
    begin
        fw_ext = CMP_W'(frame_width_reg);
        fh_ext = CMP_W'(frame_height_reg);
        if (fw_ext == '0)
            width_eff = DIM_W'(1);
        else if (fw_ext > CMP_W'(MAX_DIM))
            width_eff = DIM_W'(MAX_DIM);
        else
            width_eff = DIM_W'(fw_ext);
        if (fh_ext == '0)
            height_eff = DIM_W'(1);
        else if (fh_ext > CMP_W'(MAX_DIM))
            height_eff = DIM_W'(MAX_DIM);
        else
            height_eff = DIM_W'(fh_ext);
    end

    assign last_col    = (DIM_W'(col_reg) >= (width_eff - DIM_W'(1)));
    assign last_row    = (DIM_W'(row_reg) >= (height_eff - DIM_W'(1)));
    assign frame_start = (col_reg == '0) && (row_reg == '0);

    // Sign extension of the incoming sample from its active width.
    assign smp_shl = sample <<< SHIFT;
    assign smp     = smp_shl >>> SHIFT;
    assign off_in  = $signed({smp[SAMPLE_W-1], smp}) - RAW_OFFSET;
    assign off_sum = {{(SUM_W - STAT_W){off_in[STAT_W-1]}}, off_in};

    // Raster counters advance on every accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.accept)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : (row_reg + CNT_W'(1));
            end
            else
            begin
                col_reg <= col_reg + CNT_W'(1);
            end
        end
    end

    // Hotspot tracking and running sum, restarted at the first pixel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg     <= '0;
            max_col_reg <= '0;
            max_row_reg <= '0;
            sum_reg     <= '0;
        end
        else if (cmd.accept)
        begin
            if (frame_start)
            begin
                max_reg     <= smp;
                max_col_reg <= '0;
                max_row_reg <= '0;
                sum_reg     <= off_sum;
            end
            else
            begin
                if (smp > max_reg)
                begin
                    max_reg     <= smp;
                    max_col_reg <= col_reg;
                    max_row_reg <= row_reg;
                end
                sum_reg <= sum_reg + off_sum;
            end
        end
    end

    // Whole degrees: magnitude divided by ten through a reciprocal multiply.
    assign off_s   = $signed({samp_reg[SAMPLE_W-1], samp_reg}) - RAW_OFFSET;
    assign off_mag = off_s[STAT_W-1] ? STAT_W'(-off_s) : STAT_W'(off_s);
    assign deg_mag = DIFF_W'(prod_reg[PROD_TEN_W-1:RECIP_SHIFT]);
    assign deg_v   = off_neg_reg ? -$signed(deg_mag) : $signed(deg_mag);
    assign tmin_ext = {{(DIFF_W - TEMP_W){temp_min_reg[TEMP_W-1]}}, temp_min_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            samp_reg <= smp;
            fend_reg <= last_col && last_row;
        end
        if (cmd.mul_load)
        begin
            prod_reg    <= off_mag[SAMPLE_W-1:0] * RECIP_TEN;
            off_neg_reg <= off_s[STAT_W-1];
        end
        if (cmd.diff_load)
        begin
            diff_reg <= deg_v - tmin_ext;
        end
    end

    // Scaling: at or below the minimum, or at or above the full range, saturates directly.
    assign range_eff = (temp_range_reg == '0) ? RANGE_W'(1) : temp_range_reg;
    assign sc_zero   = diff_reg[DIFF_W-1] || (diff_reg == '0);
    assign sc_full   = !sc_zero && ($unsigned(diff_reg) >= DIFF_W'(range_eff));

    always_ff @(posedge clk)
    begin
        if (cmd.sc_sat)
        begin
            sc_reg <= sc_zero ? '0 : SC_FULL;
        end
        else if (cmd.sc_from_div)
        begin
            sc_reg <= SC_W'(div_quo[SC_FRAC_BITS-1:0]);
        end
    end

    // Shared divider: scaling fraction, then the frame average.
    assign sum_neg  = sum_reg[SUM_W-1];
    assign sum_mag  = sum_neg ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign dim_prod = width_eff * height_eff;

    always_comb
    begin
        div_start = cmd.pdiv_start || cmd.adiv_start;
        if (cmd.adiv_start)
        begin
            div_rem   = '0;
            div_dvd   = sum_mag;
            div_dvs   = DVS_W'(dim_prod);
            div_steps = STEP_W'(SUM_W);
        end
        else
        begin
            div_rem   = DVS_W'(diff_reg[RANGE_W-1:0]);
            div_dvd   = '0;
            div_dvs   = DVS_W'(range_eff);
            div_steps = STEP_W'(SC_FRAC_BITS);
        end
    end

    tfc_divider #(
        .DVD_W  (SUM_W),
        .DVS_W  (DVS_W),
        .STEP_W (STEP_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem),
        .dvd_init (div_dvd),
        .divisor  (div_dvs),
        .steps    (div_steps),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    assign avg_mag = div_quo[STAT_W-1:0];

    // Output register; it frees up in the same cycle its transaction completes.
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            pix_reg       <= palette(sc_reg);
            frame_end_reg <= fend_reg;
            if (fend_reg)
            begin
                max_tenths_reg  <= $signed({max_reg[SAMPLE_W-1], max_reg}) - RAW_OFFSET;
                max_column_reg  <= POS_W'(max_col_reg);
                max_row_out_reg <= POS_W'(max_row_reg);
                average_reg     <= sum_neg ? -$signed(avg_mag) : $signed(avg_mag);
            end
            else
            begin
                max_tenths_reg  <= '0;
                max_column_reg  <= '0;
                max_row_out_reg <= '0;
                average_reg     <= '0;
            end
        end
    end

    // Status back to the controller.
    always_comb
    begin
        status.sc_direct = sc_zero || sc_full;
        status.fend      = fend_reg;
        status.div_idle  = !div_busy;
        status.out_free  = out_free;
    end

    assign out_valid      = out_valid_reg;
    assign blue           = pix_reg.blue;
    assign green          = pix_reg.green;
    assign red            = pix_reg.red;
    assign frame_end      = frame_end_reg;
    assign max_tenths     = max_tenths_reg;
    assign max_column     = max_column_reg;
    assign max_row        = max_row_out_reg;
    assign average_tenths = average_reg;

endmodule

### design/thermal_false_color_frame_top.sv
// Channel   Direction  Handshake            Payload
// config    in         cfg_write            cfg_index, cfg_data
// input     in         in_valid / in_stall  sample
// output    out        out_valid / out_stall blue, green, red, frame_end, max_tenths,
//                                           max_column, max_row, average_tenths
//
// One pixel is processed at a time. Scaling runs a 10-step division on the shared divider,
// skipped when the scaled value saturates. The last pixel of a frame also runs the 40-step
// average division, which shares the divider.
// Reset is asynchronous and active low; it restores the register defaults and raster position.
// A finished pixel waits in the output register, so a stall on the output holds back the
// pixel that comes after it at its output load, and new input waits until that load.
module thermal_false_color_frame_top #(
    parameter int MAX_DIM     = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [tfc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tfc_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [tfc_pkg::SAMPLE_W-1:0]  sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [tfc_pkg::COLOR_W-1:0]          blue,
    output logic [tfc_pkg::COLOR_W-1:0]          green,
    output logic [tfc_pkg::COLOR_W-1:0]          red,
    output logic                                 frame_end,
    output logic signed [tfc_pkg::STAT_W-1:0]    max_tenths,
    output logic [tfc_pkg::POS_W-1:0]            max_column,
    output logic [tfc_pkg::POS_W-1:0]            max_row,
    output logic signed [tfc_pkg::STAT_W-1:0]    average_tenths
);
    import tfc_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer.
    tfc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic, statistics and output register.
    tfc_datapath #(
        .MAX_DIM     (MAX_DIM),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sample         (sample),
        .out_stall      (out_stall),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (out_valid),
        .blue           (blue),
        .green          (green),
        .red            (red),
        .frame_end      (frame_end),
        .max_tenths     (max_tenths),
        .max_column     (max_column),
        .max_row        (max_row),
        .average_tenths (average_tenths)
    );

endmodule

### design/thermal_false_color_frame_checker.sv
module thermal_false_color_frame_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic [tfc_pkg::COLOR_W-1:0]          blue,
    input logic [tfc_pkg::COLOR_W-1:0]          green,
    input logic [tfc_pkg::COLOR_W-1:0]          red,
    input logic                                 frame_end,
    input logic signed [tfc_pkg::STAT_W-1:0]    max_tenths,
    input logic [tfc_pkg::POS_W-1:0]            max_column,
    input logic [tfc_pkg::POS_W-1:0]            max_row,
    input logic signed [tfc_pkg::STAT_W-1:0]    average_tenths
);
    import tfc_pkg::*;

    // A stalled result transaction keeps its pixel, frame_end flag and average.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(blue) && $stable(green)
            && $stable(red) && $stable(frame_end) && $stable(average_tenths))
        else $error("result changed while stalled");

    // Statistics read as zero except on the last pixel of a frame.
    a_stats_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_end |-> max_tenths == '0 && max_column == '0
            && max_row == '0 && average_tenths == '0)
        else $error("statistics nonzero outside frame end");

    // The block works on one pixel at a time: busy right after an accept.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second pixel accepted back to back");

    // Green appears only in the segments where red is at full scale.
    a_palette_green: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && green != '0 |-> red == COLOR_MAX)
        else $error("green without full red");

endmodule

bind thermal_false_color_frame_top thermal_false_color_frame_checker u_checker (.*);

### bench/thermal_false_color_frame_top_test.sv
`timescale 1ns / 1ps

module thermal_false_color_frame_top_test;

    import tfc_pkg::*;

    localparam int DIM_LIMIT = 1024;

    // One false-color pixel with its frame statistics.
    typedef struct {
        logic [COLOR_W-1:0]       blue;
        logic [COLOR_W-1:0]       green;
        logic [COLOR_W-1:0]       red;
        logic                     frame_end;
        logic signed [STAT_W-1:0] max_tenths;
        logic [POS_W-1:0]         max_column;
        logic [POS_W-1:0]         max_row;
        logic signed [STAT_W-1:0] average_tenths;
    } pixel_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]           cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [COLOR_W-1:0]         blue;
    logic [COLOR_W-1:0]         green;
    logic [COLOR_W-1:0]         red;
    logic                       frame_end;
    logic signed [STAT_W-1:0]   max_tenths;
    logic [POS_W-1:0]           max_column;
    logic [POS_W-1:0]           max_row;
    logic signed [STAT_W-1:0]   average_tenths;

    // Raw samples waiting to be sent, and pixels predicted but not yet seen.
    logic signed [SAMPLE_W-1:0] samples_to_send[$];
    pixel_t                     pixels_due[$];

    // Register copies and frame tracking state of the predictor.
    logic [DIM_CFG_W-1:0]       cfg_width;
    logic [DIM_CFG_W-1:0]       cfg_height;
    logic signed [TEMP_W-1:0]   cfg_tmin;
    logic [RANGE_W-1:0]         cfg_range;
    int unsigned                col_pos;
    int unsigned                row_pos;
    int                         hot_sample;
    int unsigned                hot_col;
    int unsigned                hot_row;
    longint                     heat_sum;

    int                         mismatches = 0;
    int                         gap_left = 0;
    int                         burst_left = 0;
    int                         stall_mode = 0;
    int                         stall_tick = 0;
    pixel_t                     want;

    thermal_false_color_frame_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample         (sample),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .blue           (blue),
        .green          (green),
        .red            (red),
        .frame_end      (frame_end),
        .max_tenths     (max_tenths),
        .max_column     (max_column),
        .max_row        (max_row),
        .average_tenths (average_tenths)
    );

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // A frame dimension of zero acts as one; above the limit it saturates.
    function automatic int unsigned dim_used(logic [DIM_CFG_W-1:0] d);
        if (d == 0)
            return 1;
        if (d > DIM_LIMIT)
            return DIM_LIMIT;
        return d;
    endfunction

    // Color one sample and advance the raster and the frame statistics.
    function automatic pixel_t shade_and_track(logic signed [SAMPLE_W-1:0] s);
        int          sv;
        int          off;
        int          deg;
        int          m;
        longint      span;
        longint      scaled;
        longint      avg;
        int unsigned w;
        int unsigned h;
        bit          last_col;
        bit          last_row;
        pixel_t      p;

        sv = s;
        off = sv - 1000;
        deg = off / 10;
        span = (cfg_range == 0) ? 64'sd1 : longint'(cfg_range);
        scaled = (64'sd1024 * (longint'(deg) - longint'(cfg_tmin))) / span;
        if (scaled < 0)
            scaled = 0;
        if (scaled > 1024)
            scaled = 1024;
        m = 1024 - int'(scaled);

        // Five-segment palette on the mirrored scale.
        if (m < 256)
        begin
            p.blue = 8'(255 - m);
            p.green = 8'd255;
            p.red = 8'd255;
        end
        else if (m < 512)
        begin
            p.blue = 8'd0;
            p.green = 8'(512 - m);
            p.red = 8'd255;
        end
        else if (m < 640)
        begin
            p.blue = 8'(m - 512);
            p.green = 8'd0;
            p.red = 8'd255;
        end
        else if (m < 896)
        begin
            p.blue = 8'd128;
            p.green = 8'd0;
            p.red = (896 - m > 255) ? 8'd255 : 8'(896 - m);
        end
        else
        begin
            p.blue = 8'(1024 - m);
            p.green = 8'd0;
            p.red = 8'd0;
        end

        w = dim_used(cfg_width);
        h = dim_used(cfg_height);
        last_col = (col_pos >= w - 1);
        last_row = (row_pos >= h - 1);

        // The first pixel of a frame restarts the hotspot and the sum.
        if (col_pos == 0 && row_pos == 0)
        begin
            hot_sample = sv;
            hot_col = 0;
            hot_row = 0;
            heat_sum = 0;
        end
        else if (sv > hot_sample)
        begin
            hot_sample = sv;
            hot_col = col_pos;
            hot_row = row_pos;
        end
        heat_sum += off;

        p.frame_end = last_col && last_row;
        if (p.frame_end)
        begin
            avg = heat_sum / (longint'(w) * longint'(h));
            p.max_tenths = 17'(hot_sample - 1000);
            p.max_column = 10'(hot_col);
            p.max_row = 10'(hot_row);
            p.average_tenths = 17'(avg);
        end
        else
        begin
            p.max_tenths = '0;
            p.max_column = '0;
            p.max_row = '0;
            p.average_tenths = '0;
        end

        // Raster advance; a counter past a shrunken edge wraps here.
        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : ((row_pos + 1) & 32'h3FF);
        end
        else
            col_pos = (col_pos + 1) & 32'h3FF;
        return p;
    endfunction

    // Raw value for a temperature in whole degrees plus a tenths digit.
    function automatic logic signed [SAMPLE_W-1:0] to_raw(int deg, int digit);
        int r;

        r = 1000 + 10 * deg + digit;
        if (r < -32768)
            r = -32768;
        if (r > 32767)
            r = 32767;
        return 16'(r);
    endfunction

    function automatic logic [DIM_CFG_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0: return 11'd0;
            1: return 11'd1;
            2: return 11'd2047;
            3: return 11'd1024;
            4: return 11'($urandom_range(1025, 2047));
            default: return 11'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic signed [TEMP_W-1:0] pick_tmin();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'($urandom);
            default: return 16'(-50 + int'($urandom_range(0, 150)));
        endcase
    endfunction

    function automatic logic [RANGE_W-1:0] pick_range();
        case ($urandom_range(0, 6))
            0: return 15'd0;
            1: return 15'd1;
            2: return 15'h7FFF;
            3: return 15'($urandom_range(1, 32767));
            default: return 15'($urandom_range(1, 400));
        endcase
    endfunction

    function automatic void compare_field(string field, logic signed [63:0] want_v,
                                          logic signed [63:0] got_v);
        if (got_v !== want_v)
        begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, field, want_v, got_v);
        end
    endfunction

    // Register write while the block is idle; the predictor copy follows it.
    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_FRAME_WIDTH:  cfg_width = data[DIM_CFG_W-1:0];
            REG_FRAME_HEIGHT: cfg_height = data[DIM_CFG_W-1:0];
            REG_TEMP_MIN:     cfg_tmin = data;
            REG_TEMP_RANGE:   cfg_range = data[RANGE_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Idle means nothing left to send, nothing in flight and nothing awaited.
    task automatic wait_idle();
        @(negedge clk);
        while (samples_to_send.size() != 0 || in_valid || pixels_due.size() != 0)
            @(negedge clk);
    endtask

    // Sender: bursts of transactions separated by random gaps.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                pixels_due.push_back(shade_and_track(sample));
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (samples_to_send.size() > 0)
                begin
                    in_valid <= 1'b1;
                    sample <= samples_to_send.pop_front();
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: check each accepted pixel, and stall on a shifting pattern.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid === 1'b1 && out_stall == 1'b0)
            begin
                if (pixels_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 40)
                        $display("%0t ns: pixel with none expected, expected none, actual %0d",
                                 $time, {red, green, blue});
                end
                else
                begin
                    want = pixels_due.pop_front();
                    compare_field("blue", want.blue, blue);
                    compare_field("green", want.green, green);
                    compare_field("red", want.red, red);
                    compare_field("frame_end", want.frame_end, frame_end);
                    compare_field("max_tenths", want.max_tenths, max_tenths);
                    compare_field("max_column", want.max_column, max_column);
                    compare_field("max_row", want.max_row, max_row);
                    compare_field("average_tenths", want.average_tenths, average_tenths);
                end
            end

            stall_tick++;
            if (stall_tick % 97 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 9) < 7);
                default: out_stall <= ((stall_tick % 16) < 6);
            endcase
        end
    end

    // Stimulus: a directed opening, then random phases with new settings.
    initial
    begin
        int                         sent;
        int                         phase;
        int                         n;
        int                         style;
        int                         span_i;
        int                         deg;
        logic signed [SAMPLE_W-1:0] tie_a;
        logic signed [SAMPLE_W-1:0] tie_b;
        logic [DIM_CFG_W-1:0]       w;
        logic [DIM_CFG_W-1:0]       h;
        logic signed [TEMP_W-1:0]   tm;
        logic [RANGE_W-1:0]         rg;

        cfg_width = WIDTH_RESET;
        cfg_height = HEIGHT_RESET;
        cfg_tmin = TMIN_RESET;
        cfg_range = RANGE_RESET;
        col_pos = 0;
        row_pos = 0;
        hot_sample = 0;
        hot_col = 0;
        hot_row = 0;
        heat_sum = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // A few pixels under the reset settings, starting the first frame.
        @(negedge clk);
        samples_to_send.push_back(to_raw(50, 0));
        samples_to_send.push_back(to_raw(75, 0));
        samples_to_send.push_back(16'sh7FFF);
        wait_idle();

        // With a range of 1024 and a zero minimum the scale equals the degrees,
        // so each palette knee can be hit exactly. The width change lands
        // mid-frame with the column already on the new last column.
        write_reg(REG_FRAME_WIDTH, 16'd4);
        write_reg(REG_FRAME_HEIGHT, 16'd5);
        write_reg(REG_TEMP_MIN, 16'd0);
        write_reg(REG_TEMP_RANGE, 16'd1024);
        @(negedge clk);
        samples_to_send.push_back(to_raw(1024, 0));
        samples_to_send.push_back(to_raw(769, 3));
        samples_to_send.push_back(to_raw(768, 9));
        samples_to_send.push_back(16'sh7FFF);
        samples_to_send.push_back(to_raw(513, 0));
        samples_to_send.push_back(to_raw(512, 5));
        samples_to_send.push_back(to_raw(385, 0));
        samples_to_send.push_back(to_raw(384, 0));
        samples_to_send.push_back(to_raw(383, 0));
        samples_to_send.push_back(to_raw(129, 0));
        samples_to_send.push_back(to_raw(128, 0));
        samples_to_send.push_back(to_raw(1, 0));
        samples_to_send.push_back(16'sd1009);
        samples_to_send.push_back(16'sd991);
        samples_to_send.push_back(16'sd981);
        samples_to_send.push_back(16'sh8000);
        // A second copy of the hottest value must not move the hotspot.
        samples_to_send.push_back(16'sh7FFF);
        samples_to_send.push_back(16'sd0);
        samples_to_send.push_back(-16'sd1);
        samples_to_send.push_back(16'sd1000);

        sent = 0;
        for (phase = 0; sent < 1550; phase++)
        begin
            wait_idle();

            // The first phases pin the register extremes; later ones roam.
            if (phase < 4)
            begin
                case (phase)
                    0:
                    begin
                        w = 11'd0;
                        h = 11'd0;
                        tm = 16'sh8000;
                        rg = 15'd0;
                    end
                    1:
                    begin
                        w = 11'd2047;
                        h = 11'd2047;
                        tm = 16'sh7FFF;
                        rg = 15'h7FFF;
                    end
                    2:
                    begin
                        w = 11'd1;
                        h = 11'd1024;
                        tm = 16'sd0;
                        rg = 15'd1;
                    end
                    default:
                    begin
                        w = 11'd1024;
                        h = 11'd1;
                        tm = -16'sd100;
                        rg = 15'd200;
                    end
                endcase
                write_reg(REG_FRAME_WIDTH, {5'($urandom), w});
                write_reg(REG_FRAME_HEIGHT, {5'($urandom), h});
                write_reg(REG_TEMP_MIN, tm);
                write_reg(REG_TEMP_RANGE, {1'($urandom), rg});
            end
            else
            begin
                if ($urandom_range(0, 3) != 0)
                    write_reg(REG_FRAME_WIDTH, {5'($urandom), pick_dim()});
                if ($urandom_range(0, 3) != 0)
                    write_reg(REG_FRAME_HEIGHT, {5'($urandom), pick_dim()});
                if ($urandom_range(0, 3) != 0)
                    write_reg(REG_TEMP_MIN, pick_tmin());
                if ($urandom_range(0, 3) != 0)
                    write_reg(REG_TEMP_RANGE, {1'($urandom), pick_range()});
            end

            @(negedge clk);
            n = $urandom_range(8, 48);
            style = $urandom_range(0, 3);
            span_i = (cfg_range == 0) ? 1 : int'(cfg_range);
            tie_a = 16'($urandom);
            tie_b = 16'($urandom);
            repeat (n)
            begin
                case (style)
                    // Full-range raw values.
                    0: samples_to_send.push_back(16'($urandom));
                    // Temperatures spread over the palette and a little past it.
                    1:
                    begin
                        deg = int'(cfg_tmin) - span_i / 8 +
                              int'($urandom_range(0, span_i + span_i / 4));
                        samples_to_send.push_back(to_raw(deg, $urandom_range(0, 9)));
                    end
                    // Few distinct values, so hotspot ties are common.
                    2: samples_to_send.push_back(($urandom_range(0, 1) == 0) ? tie_a : tie_b);
                    default:
                    begin
                        case ($urandom_range(0, 3))
                            0: samples_to_send.push_back(16'sh8000);
                            1: samples_to_send.push_back(16'sh7FFF);
                            default: samples_to_send.push_back(16'($urandom));
                        endcase
                    end
                endcase
            end
            sent += n;
        end

        // Drain, then allow for the slowest pixel before the verdict.
        wait_idle();
        repeat (64) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #8_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
design/tfc_pkg.sv
design/tfc_divider.sv
design/tfc_ctrl.sv
design/tfc_datapath.sv
design/thermal_false_color_frame_top.sv
design/thermal_false_color_frame_checker.sv
bench/thermal_false_color_frame_top_test.sv
